// File: rtl/b64e_pkg.sv
// ---------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-character mapping for the
// base64 stream encoder.
// ---------------------------------------------------------------------------
package b64e_pkg;

  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='
  localparam logic [7:0] CHAR_NL      = 8'h0A;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;

  localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;
  localparam logic [8:0] GROUP_COLS        = 9'd4;

  // Character slot indexes within a group
  localparam logic [2:0] SLOT_THIRD = 3'd2;
  localparam logic [2:0] SLOT_LAST  = 3'd3;
  localparam logic [2:0] SLOT_NL    = 3'd4;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // One queued group: 24 data bits, index of its final character,
  // number of trailing pad characters, and the finish flag.
  typedef struct packed {
    logic [23:0] bits;
    logic [2:0]  last_idx;
    logic [1:0]  pads;
    logic        fin;
  } group_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = CHAR_UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CHAR_LOWER_A + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = CHAR_DIGIT_0 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

// File: rtl/b64e_front.sv
// ---------------------------------------------------------------------------
// b64e_front
// Accepts input items, collects bytes into groups of three, tracks the line
// column and pushes complete or flushed groups into the queue.
// ---------------------------------------------------------------------------
module b64e_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      line_length,
  input  logic            acc,
  input  logic            command,
  input  logic [7:0]      data_byte,
  output logic            push,
  output b64e_pkg::group_t push_grp
);
  import b64e_pkg::*;

  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] col_r, col_nxt;
  logic [8:0] col_sum;
  logic       wrap;

  // Column summed at full width, so it never wraps before the compare
  assign col_sum = {1'b0, col_r} + GROUP_COLS;
  assign wrap    = (col_sum >= {1'b0, line_length});

  always_comb begin
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    push      = 1'b0;
    push_grp  = '0;
    if (acc) begin
      if (command == CMD_DATA) begin
        if (cnt_r == 2'd0) begin
          held0_nxt = data_byte;
          cnt_nxt   = 2'd1;
        end else if (cnt_r == 2'd1) begin
          held1_nxt = data_byte;
          cnt_nxt   = 2'd2;
        end else begin
          push              = 1'b1;
          push_grp.bits     = {held0_r, held1_r, data_byte};
          push_grp.last_idx = wrap ? SLOT_NL : SLOT_LAST;
          push_grp.pads     = 2'd0;
          push_grp.fin      = 1'b0;
          col_nxt           = wrap ? 8'd0 : col_sum[7:0];
          cnt_nxt           = 2'd0;
        end
      end else if (cnt_r != 2'd0) begin
        push              = 1'b1;
        push_grp.bits     = {held0_r, (cnt_r == 2'd2) ? held1_r : 8'd0, 8'd0};
        push_grp.last_idx = SLOT_LAST;
        push_grp.pads     = (cnt_r == 2'd2) ? 2'd1 : 2'd2;
        push_grp.fin      = 1'b1;
        col_nxt           = 8'd0;
        cnt_nxt           = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 2'd0;
      col_r   <= 8'd0;
      held0_r <= 8'd0;
      held1_r <= 8'd0;
    end else begin
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

endmodule

// File: rtl/b64e_queue.sv
// ---------------------------------------------------------------------------
// b64e_queue
// Small register queue of groups between the front and the serializer.
// ---------------------------------------------------------------------------
module b64e_queue #(
  parameter int Depth = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64e_pkg::group_t push_grp,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output b64e_pkg::group_t head
);
  import b64e_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  group_t          mem_r [Depth];
  logic [PtrW-1:0] wp_r, wp_nxt;
  logic [PtrW-1:0] rp_r, rp_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CntFull);
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PtrLast) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PtrLast) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_grp;
    end
  end

endmodule

// File: rtl/b64e_back.sv
// ---------------------------------------------------------------------------
// b64e_back
// Serializes the queue head one character per cycle, while out_stall is low,
// into the output register, popping the group as its final character loads.
// ---------------------------------------------------------------------------
module b64e_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             grp_valid,
  input  b64e_pkg::group_t grp,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_char,
  output logic             out_last_of_run,
  output logic             out_message_end
);
  import b64e_pkg::*;

  logic       vld_r, vld_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] char_r;
  logic       last_r;
  logic       fin_r;
  logic       load;
  logic       is_last;
  logic       is_pad;
  logic [5:0] sextet;
  logic [7:0] ch;

  assign load    = grp_valid && (!vld_r || !out_stall);
  assign is_last = (idx_r == grp.last_idx);
  assign pop     = load && is_last;

  // Trailing pad slots depend on how many bytes the flushed group held
  assign is_pad = ((idx_r == SLOT_LAST) && (grp.pads != 2'd0)) ||
                  ((idx_r == SLOT_THIRD) && (grp.pads == 2'd2));

  always_comb begin
    unique case (idx_r[1:0])
      2'd0:    sextet = grp.bits[23:18];
      2'd1:    sextet = grp.bits[17:12];
      2'd2:    sextet = grp.bits[11:6];
      default: sextet = grp.bits[5:0];
    endcase
  end

  always_comb begin
    priority if (idx_r == SLOT_NL) begin
      ch = CHAR_NL;
    end else if (is_pad) begin
      ch = CHAR_PAD;
    end else begin
      ch = sextet_char(sextet);
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = is_last ? 3'd0 : idx_r + 3'd1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 3'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= ch;
      last_r <= is_last;
      fin_r  <= grp.fin;
    end
  end

  assign out_valid       = vld_r;
  assign out_char        = char_r;
  assign out_last_of_run = last_r;
  assign out_message_end = fin_r;

endmodule

// File: rtl/base64_stream_encoder_core.sv
// ---------------------------------------------------------------------------
// base64_stream_encoder_core
// Line-wrapped base64 stream encoder with a byte input and character output.
// ---------------------------------------------------------------------------
// Bytes go in one item at a time; every third byte produces four base64
// characters, followed by a newline when the line column reaches the
// programmed line length. A finish item flushes one or two held bytes as
// four characters padded with '=' and clears the column. The front stage
// takes one item per cycle while the group queue has room; the output side
// emits one character per cycle while out_stall is low, so sustained
// throughput is set by the serializer, which emits four characters per
// three-byte group, plus a newline when the line wraps. A completing byte's
// group is written into the queue and then loaded into the output register.
// line_length resets to 76 and may be written only while the block is idle.
module base64_stream_encoder_core #(
  parameter int QueueDepth = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  output logic       out_message_end
);
  import b64e_pkg::*;

  logic [7:0] line_length_r;
  logic       in_acc;
  logic       push;
  group_t     push_grp;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;
  group_t     q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= LINE_LENGTH_RESET;
    end else if (cfg_we) begin
      line_length_r <= cfg_wdata;
    end
  end

  assign in_stall = q_full;
  assign in_acc   = in_valid && !q_full;

  b64e_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .line_length (line_length_r),
    .acc         (in_acc),
    .command     (in_command),
    .data_byte   (in_data_byte),
    .push        (push),
    .push_grp    (push_grp)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_grp  (push_grp),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  b64e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .grp_valid       (q_not_empty),
    .grp             (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .out_message_end (out_message_end)
  );

endmodule

// File: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line-wrapped base64 stream encoder.
// ---------------------------------------------------------------------------
// Bytes and finish items are driven on the input channel while a predictor
// tracks the held bytes, the line column and the line length, and queues
// the characters each item should produce. Every accepted output character
// is checked field by field against the oldest queued one. Directed cases
// cover the alphabet corners, padding and line wrap at the length extremes;
// random messages then run under several sender/receiver idling mixes, and
// one long run of groups goes against a receiver that holds off for a long
// stretch.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b64e_pkg::*;

  localparam int LONG_HOLD    = 150;
  localparam int SETTLE_WAIT  = 8;
  localparam int RANDOM_ITEMS = 30;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       fin;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_command = CMD_DATA;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_last_of_run;
  logic       out_message_end;

  // predictor state
  logic [7:0] line_len = LINE_LENGTH_RESET;
  logic [7:0] held [2] = '{8'h00, 8'h00};
  logic [1:0] held_cnt = 2'd0;
  logic [7:0] column = 8'h00;
  enc_char_t  pending_chars[$];

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;

  base64_stream_encoder_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .out_message_end (out_message_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic logic [7:0] b64_symbol(input logic [5:0] s);
    string alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    return alphabet[s];
  endfunction

  // Update the encoder state for one accepted item and queue its characters
  task automatic encode_item(input logic cmd, input logic [7:0] b);
    logic [23:0] grp;
    logic [8:0]  col_sum;
    enc_char_t   run [5];
    int          n;
    n = 0;
    if (cmd == CMD_DATA) begin
      if (held_cnt < 2'd2) begin
        held[held_cnt] = b;
        held_cnt = held_cnt + 2'd1;
        return;
      end
      grp = {held[0], held[1], b};
      for (int k = 0; k < 4; k++) begin
        run[n] = '{b64_symbol(6'(grp >> (18 - 6 * k))), 1'b0, 1'b0};
        n++;
      end
      col_sum = {1'b0, column} + 9'd4;
      if (col_sum >= {1'b0, line_len}) begin
        run[n] = '{CHAR_NL, 1'b0, 1'b0};
        n++;
        column = 8'h00;
      end else begin
        column = col_sum[7:0];
      end
    end else begin
      if (held_cnt == 2'd0) return;
      grp = {held[0], (held_cnt == 2'd2) ? held[1] : 8'h00, 8'h00};
      run[0] = '{b64_symbol(grp[23:18]), 1'b0, 1'b1};
      run[1] = '{b64_symbol(grp[17:12]), 1'b0, 1'b1};
      run[2] = '{(held_cnt == 2'd2) ? b64_symbol(grp[11:6]) : CHAR_PAD, 1'b0, 1'b1};
      run[3] = '{CHAR_PAD, 1'b0, 1'b1};
      n = 4;
      column = 8'h00;
    end
    held[0] = 8'h00;
    held[1] = 8'h00;
    held_cnt = 2'd0;
    run[n - 1].last = 1'b1;
    for (int k = 0; k < n; k++) pending_chars.push_back(run[k]);
  endtask

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $realtime, what, exp_v, got_v);
    mismatch_count++;
  endtask

  // Receiver: random stall, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Character checker
  always @(posedge clk) begin
    enc_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected character", 0, out_char);
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch) report_mismatch("out_char", want.ch, out_char);
        if (out_last_of_run !== want.last)
          report_mismatch("out_last_of_run", want.last, out_last_of_run);
        if (out_message_end !== want.fin)
          report_mismatch("out_message_end", want.fin, out_message_end);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    encode_item(cmd, b);
  endtask

  task automatic send_bytes3(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    send_item(CMD_DATA, b0);
    send_item(CMD_DATA, b1);
    send_item(CMD_DATA, b2);
  endtask

  // Wait for every queued character, then let any held-byte update settle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_line_length(input logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    line_len = v;
  endtask

  task automatic test_padding;
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(CMD_FINISH, 8'hA5);            // nothing held: no output
    send_bytes3(8'h00, 8'h00, 8'h00);
    send_bytes3(8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_FINISH, 8'h5A);            // one byte: two pads
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_FINISH, 8'hFF);            // two bytes: one pad
    send_item(CMD_FINISH, 8'h00);
  endtask

  task automatic test_line_wrap;
    write_line_length(8'd1);
    send_bytes3(8'hFB, 8'hEF, 8'hBE);
    write_line_length(8'd0);                 // newline after every group
    send_bytes3(8'h4D, 8'h61, 8'h6E);
    write_line_length(8'd252);
    send_bytes3(8'h12, 8'h34, 8'h56);
    write_line_length(8'd2);                 // column already past new length
    send_bytes3(8'h78, 8'h9A, 8'hBC);
    write_line_length(8'd255);
    send_item(CMD_DATA, 8'hDE);
    send_item(CMD_DATA, 8'hAD);
    send_item(CMD_FINISH, 8'h00);
  endtask

  // Long run of groups across a line wrap against a long receiver hold-off
  task automatic test_long_line;
    write_line_length(8'd40);
    send_idle_pct = 0;
    stall_pct = 53;
    holds_asked++;
    for (int k = 0; k < 46; k++) send_item(CMD_DATA, 8'($urandom));
    send_item(CMD_DATA, 8'($urandom));
    send_item(CMD_FINISH, 8'($urandom));
  endtask

  // Mostly well-formed messages with random content, some stray items
  task automatic test_random_messages(input int idle_p, input int stall_p,
                                      input logic [7:0] len);
    int sent;
    int msg_len;
    logic cmd;
    write_line_length(len);
    send_idle_pct = idle_p;
    stall_pct = stall_p;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 80) begin
        msg_len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(14);
        for (int k = 0; k < msg_len; k++) send_item(CMD_DATA, 8'($urandom));
        sent += msg_len;
        if (held_cnt != 2'd0) sent++;
        send_item(CMD_FINISH, 8'($urandom));
      end else begin
        cmd = 1'($urandom);
        if (cmd == CMD_DATA || held_cnt != 2'd0) sent++;
        send_item(cmd, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_padding();
    test_line_wrap();
    test_random_messages(0, 0, 8'd76);
    test_random_messages(53, 0, 8'd1);
    test_random_messages(0, 53, 8'd252);
    test_random_messages(20, 20, 8'($urandom_range(1, 252)));
    test_long_line();
    drain();
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_core.sv
test/tb_top.sv
